/* hdl/assert_macros.svh */
// Assertion helpers for the checker module of the color converter.
// Needs nothing else; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define HSL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property at every rising edge, reset included.
`define HSL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hdl/hsl2rgb_pkg.sv */
// Shared types and Q0.16 constants for the HSL to RGB converter.
// No dependencies; every module of the block imports it.
`default_nettype none

package hsl2rgb_pkg;

  // Request payload: three unsigned Q0.16 fractions
  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;
  } hsl_t;

  // Result payload: 8-bit channels
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Grey bypass carried alongside the color path
  typedef struct packed {
    logic       flag;
    logic [7:0] level;
  } grey_t;

  // Load enables of the per-channel stages
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

  // Hue ramp segments
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_TOP,
    SEG_FALL,
    SEG_FLOOR
  } seg_t;

  // Fractions rounded to Q0.16
  localparam logic [15:0] FX_SIXTH     = 16'd10923;
  localparam logic [15:0] FX_HALF      = 16'd32768;
  localparam logic [15:0] FX_TWOTHIRDS = 16'd43691;
  localparam logic [15:0] FX_THIRD     = 16'd21845;

endpackage

`default_nettype wire

/* hdl/hsl_to_rgb_converter_unit.sv */
// HSL to RGB converter, top level: request channel in_*, result channel out_*.
// Uses hsl2rgb_pkg and three hsl2rgb_chan instances.
//
// Usage:
//   A request carries hue, saturation and lightness as unsigned Q0.16 fractions
//   and is taken when in_valid and in_ready are both high. Each request gives
//   exactly one result of 8-bit red, green and blue, offered on out_data with
//   out_valid until out_ready takes it.
//   Throughput is one request per cycle while the output is not stalled: six
//   register stages (product l*s, q, p with span and slope factor, ramp
//   multiply, ramp sum, 255 scaling) each hold one request, and each stage
//   carries its own valid bit.
//   A stage loads whenever it is empty or the stage after it moves, so bubbles
//   close up while the output waits. When out_ready stays low the result holds,
//   the pipeline fills behind it, and in_ready drops only once every stage is
//   occupied. With out_ready high, in_ready is high as well.
//   Zero saturation bypasses the ramp and returns lightness*255 on all channels.
//   Synchronous active-low reset empties the pipeline; no result is shown until
//   a new request arrives.
`default_nettype none

module hsl_to_rgb_converter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsl2rgb_pkg::hsl_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsl2rgb_pkg::rgb_t  out_data
);
  import hsl2rgb_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  grey_t           gry_r [NSTG];
  grey_t           gry_nxt;
  stage_en_t       chan_en;

  logic [23:0]     l255;
  logic [31:0]     ls_nxt;
  logic [15:0]     h_r1;
  logic [15:0]     s_r1;
  logic [15:0]     l_r1;
  logic [31:0]     ls_r1;

  logic [33:0]     q_hi;
  logic [31:0]     q_nxt;
  logic [31:0]     q_r2;
  logic [15:0]     l_r2;
  logic [15:0]     tr_r2;
  logic [15:0]     tg_r2;
  logic [15:0]     tb_r2;

  logic [32:0]     p_full;
  logic [32:0]     d_full;
  logic [31:0]     p_r3;
  logic [31:0]     q_r3;
  logic [31:0]     d_r3;

  logic [7:0]      red_lvl;
  logic [7:0]      green_lvl;
  logic [7:0]      blue_lvl;

  // Backpressure: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NSTG-1] = ~vld_r[NSTG-1] | out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = ~vld_r[i] | rdy[i+1];
    end
  end

  // Advance valid bits
  always_comb begin
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NSTG-1];

  // Stage 1: l*s and the grey level
  assign ls_nxt        = 32'(in_data.lightness) * 32'(in_data.saturation);
  assign l255          = {in_data.lightness, 8'h00} - {8'h00, in_data.lightness};
  assign gry_nxt.flag  = (in_data.saturation == 16'h0000);
  assign gry_nxt.level = l255[23:16];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      h_r1     <= in_data.hue;
      s_r1     <= in_data.saturation;
      l_r1     <= in_data.lightness;
      ls_r1    <= ls_nxt;
      gry_r[0] <= gry_nxt;
    end
  end

  // Stage 2: q and the three ramp positions
  assign q_hi  = {2'b00, l_r1, 16'h0000} + {2'b00, s_r1, 16'h0000} - {2'b00, ls_r1};
  assign q_nxt = (l_r1 < FX_HALF) ? ({l_r1, 16'h0000} + ls_r1) : q_hi[31:0];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      q_r2     <= q_nxt;
      l_r2     <= l_r1;
      tr_r2    <= h_r1 + FX_THIRD;
      tg_r2    <= h_r1;
      tb_r2    <= h_r1 - FX_THIRD;
      gry_r[1] <= gry_r[0];
    end
  end

  // Stage 3: p = 2l - q and span d = 2q - 2l
  assign p_full = {l_r2, 17'h00000} - {1'b0, q_r2};
  assign d_full = {q_r2, 1'b0} - {l_r2, 17'h00000};

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      p_r3     <= p_full[31:0];
      q_r3     <= q_r2;
      d_r3     <= d_full[31:0];
      gry_r[2] <= gry_r[1];
    end
  end

  // Carry the grey bypass through the channel stages
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      gry_r[3] <= gry_r[2];
    end
    if (rdy[4]) begin
      gry_r[4] <= gry_r[3];
    end
    if (rdy[5]) begin
      gry_r[5] <= gry_r[4];
    end
  end

  assign chan_en.s3 = rdy[2];
  assign chan_en.s4 = rdy[3];
  assign chan_en.s5 = rdy[4];
  assign chan_en.s6 = rdy[5];

  hsl2rgb_chan u_red (
    .clk   (clk),
    .en    (chan_en),
    .t     (tr_r2),
    .p     (p_r3),
    .q     (q_r3),
    .d     (d_r3),
    .level (red_lvl)
  );

  hsl2rgb_chan u_green (
    .clk   (clk),
    .en    (chan_en),
    .t     (tg_r2),
    .p     (p_r3),
    .q     (q_r3),
    .d     (d_r3),
    .level (green_lvl)
  );

  hsl2rgb_chan u_blue (
    .clk   (clk),
    .en    (chan_en),
    .t     (tb_r2),
    .p     (p_r3),
    .q     (q_r3),
    .d     (d_r3),
    .level (blue_lvl)
  );

  // Select grey or color result
  always_comb begin
    if (gry_r[NSTG-1].flag) begin
      out_data.red   = gry_r[NSTG-1].level;
      out_data.green = gry_r[NSTG-1].level;
      out_data.blue  = gry_r[NSTG-1].level;
    end else begin
      out_data.red   = red_lvl;
      out_data.green = green_lvl;
      out_data.blue  = blue_lvl;
    end
  end

endmodule

`default_nettype wire

/* hdl/hsl2rgb_chan.sv */
// One color channel: hue ramp segment, ramp multiply, sum and 255 scaling.
// Stages 3 to 6 of the converter pipeline; uses hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_chan (
  input  logic                  clk,
  input  hsl2rgb_pkg::stage_en_t en,
  input  logic [15:0]           t,
  input  logic [31:0]           p,
  input  logic [31:0]           q,
  input  logic [31:0]           d,
  output logic [7:0]            level
);
  import hsl2rgb_pkg::*;

  logic [18:0] rise_k;
  logic [15:0] fall_t;
  logic [18:0] fall_k;
  seg_t        seg_nxt;
  logic [16:0] k_nxt;
  seg_t        seg_r;
  logic [16:0] k_r;
  logic [31:0] base_nxt;
  logic [48:0] prod_nxt;
  logic [31:0] base_r;
  logic [48:0] prod_r;
  logic [48:0] v_nxt;
  logic [48:0] v_r;
  logic [56:0] scaled;
  logic [7:0]  level_nxt;
  logic [7:0]  level_r;

  // Classify ramp position and form the slope factor 6*t or 6*(2/3 - t)
  always_comb begin
    rise_k  = {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
    fall_t  = FX_TWOTHIRDS - t;
    fall_k  = {1'b0, fall_t, 2'b00} + {2'b00, fall_t, 1'b0};
    seg_nxt = SEG_FLOOR;
    k_nxt   = '0;
    if (t < FX_SIXTH) begin
      seg_nxt = SEG_RISE;
      k_nxt   = rise_k[16:0];
    end else if (t < FX_HALF) begin
      seg_nxt = SEG_TOP;
    end else if (t < FX_TWOTHIRDS) begin
      seg_nxt = SEG_FALL;
      k_nxt   = fall_k[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      seg_r <= seg_nxt;
      k_r   <= k_nxt;
    end
  end

  // Pick the base level and multiply the span by the slope factor
  always_comb begin
    base_nxt = p;
    prod_nxt = '0;
    case (seg_r)
      SEG_RISE, SEG_FALL: prod_nxt = 49'(d) * 49'(k_r);
      SEG_TOP:            base_nxt = q;
      default:            base_nxt = p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      base_r <= base_nxt;
      prod_r <= prod_nxt;
    end
  end

  // Add the base level in Q0.48
  assign v_nxt = {1'b0, base_r, 16'h0000} + prod_r;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      v_r <= v_nxt;
    end
  end

  // Scale by 255, truncate, and clamp the slight overshoot past q
  assign scaled    = {v_r, 8'h00} - {8'h00, v_r};
  assign level_nxt = scaled[56] ? 8'hFF : scaled[55:48];

  always_ff @(posedge clk) begin
    if (en.s6) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

/* hdl/hsl2rgb_checker.sv */
// Port-level checks of the HSL to RGB converter, bound to its top level.
// Uses hsl2rgb_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hsl2rgb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input hsl2rgb_pkg::hsl_t in_data,
  input logic              out_valid,
  input logic              out_ready,
  input hsl2rgb_pkg::rgb_t out_data
);
  import hsl2rgb_pkg::*;

  // Reset empties the pipeline
  `HSL_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n) |-> !out_valid)
  // A free output never stalls the input side
  `HSL_ASSERT(a_ready_flow, clk, rst_n, out_ready |-> in_ready)
  // A waiting request stays offered with its payload unchanged
  `HSL_ASSERT(a_hold_req, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data))
  // A stalled result stays offered
  `HSL_ASSERT(a_hold_valid, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // A stalled result keeps its value
  `HSL_ASSERT(a_hold_data, clk, rst_n, out_valid && !out_ready |=> $stable(out_data))

endmodule

bind hsl_to_rgb_converter_unit hsl2rgb_checker u_hsl2rgb_checker (.*);

`default_nettype wire
